// File: src/yrfr_pkg.sv
// ----------------------------------------------------------------------------
// yrfr_pkg
// Shared types and constants of the YUV 4:2:0 to RGB converter with flip and
// rotate addressing.
// ----------------------------------------------------------------------------
package yrfr_pkg;

    localparam int SAMPLE_W = 6;
    localparam int SIZE_W   = 11;
    localparam int PIXEL_W  = 24;
    localparam int ADDR_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int OFF_W    = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_ROTATE_MODE  = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [SIZE_W-1:0] SIZE_CAP     = 11'd2046;

    localparam logic [SIZE_W-1:0] CB_BIAS = 11'd260;
    localparam logic [SIZE_W-1:0] G_BIAS  = 11'd124;
    localparam logic [SIZE_W-1:0] R_BIAS  = 11'd146;
    localparam logic [7:0]        CHAN_MAX = 8'd255;

    typedef logic [1:0] pixel_sel_t;
    localparam pixel_sel_t LAST_PIXEL = 2'd3;

endpackage

// File: src/yuv420_to_rgb32_flip_rotate_top.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb32_flip_rotate_top
// Converts 2x2 YUV 4:2:0 quads to packed 24-bit RGB pixels with frame-buffer
// addresses for a vertically flipped or a transposed output layout.
// ----------------------------------------------------------------------------
// Each input item is one 2x2 luma quad with its shared U and V samples, sent in
// raster order of quads. The block returns four result items per quad, in the
// order top-left, top-right, bottom-left, bottom-right, each with a packed
// pixel (blue in bits 0-7, green 8-15, red 16-23) and its word address in the
// output frame buffer. The result channel moves one pixel per cycle while
// out_stall is low. A quad is held in an input register while the previous
// quad drains from the output stage, so a new quad is taken in the same cycle
// as the last pixel of the current one leaves the output stage. When the block
// is empty, an accepted quad passes the input register and then the output
// stage before its first pixel shows on the result port. In normal mode source
// row y lands on output row (H-1-y); in rotate mode source pixel (x,y) lands at
// x*H + y. Odd sizes drop their low bit, sizes below 2 count as 2, and sizes
// above MAX_WIDTH or MAX_HEIGHT are capped. Registers must be written by the
// user only while the block is idle; the block does not enforce this. The quad
// position counters are not cleared by register writes and wrap at frame end.
// ----------------------------------------------------------------------------
module yuv420_to_rgb32_flip_rotate_top
    import yrfr_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  luma_top_left,
    input  logic [SAMPLE_W-1:0]  luma_top_right,
    input  logic [SAMPLE_W-1:0]  luma_bottom_left,
    input  logic [SAMPLE_W-1:0]  luma_bottom_right,
    input  logic [SAMPLE_W-1:0]  chroma_u,
    input  logic [SAMPLE_W-1:0]  chroma_v,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIXEL_W-1:0]   pixel_word,
    output logic [ADDR_W-1:0]    pixel_address,
    output logic                 quad_last,
    output logic                 frame_last
);

    // Effective size limits: even, at least 2, and never above what the
    // 11-bit size registers can express once made even.
    localparam int W_EVEN = (MAX_WIDTH / 2) * 2;
    localparam int H_EVEN = (MAX_HEIGHT / 2) * 2;
    localparam int W_LIM  = (W_EVEN < 2) ? 2
                            : ((W_EVEN > int'(SIZE_CAP)) ? int'(SIZE_CAP) : W_EVEN);
    localparam int H_LIM  = (H_EVEN < 2) ? 2
                            : ((H_EVEN > int'(SIZE_CAP)) ? int'(SIZE_CAP) : H_EVEN);
    localparam int QCW    = $clog2(W_LIM / 2 + 1);
    localparam int QRW    = $clog2(H_LIM / 2 + 1);

    localparam logic [SIZE_W-1:0] W_LIM_V = SIZE_W'(W_LIM);
    localparam logic [SIZE_W-1:0] H_LIM_V = SIZE_W'(H_LIM);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              rotate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            rotate_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_ROTATE_MODE:  rotate_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] s;
        begin
            s = {raw[SIZE_W-1:1], 1'b0};
            if (s < 11'd2)
            begin
                s = 11'd2;
            end
            if (s > lim)
            begin
                s = lim;
            end
            return s;
        end
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [SIZE_W-1:0] val);
        begin
            if (val < 0)
            begin
                return 8'd0;
            end
            else if (val > $signed({3'b000, CHAN_MAX}))
            begin
                return CHAN_MAX;
            end
            else
            begin
                return val[7:0];
            end
        end
    endfunction

    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [SIZE_W-1:0] qw;
    logic [SIZE_W-1:0] qh;

    assign w_eff = eff_size(width_reg, W_LIM_V);
    assign h_eff = eff_size(height_reg, H_LIM_V);
    assign qw    = {1'b0, w_eff[SIZE_W-1:1]};
    assign qh    = {1'b0, h_eff[SIZE_W-1:1]};

    // ------------------------------------------------------------------
    // Handshake control. Stage A is the input register, stage B the output
    // stage that walks through the four pixels of one quad.
    // ------------------------------------------------------------------
    logic       a_valid_reg;
    logic       b_valid_reg;
    pixel_sel_t k_reg;
    logic       out_take;
    logic       b_finish;
    logic       load_b;
    logic       in_take;

    assign out_take = b_valid_reg && !out_stall;
    assign b_finish = out_take && (k_reg == LAST_PIXEL);
    assign load_b   = a_valid_reg && (!b_valid_reg || b_finish);
    assign in_stall = a_valid_reg && !load_b;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Quad position counters. The position of a quad is fixed when it is
    // accepted; a shrunken frame size wraps the counters first.
    // ------------------------------------------------------------------
    logic [QCW-1:0]    col_reg;
    logic [QRW-1:0]    row_reg;
    logic [QCW-1:0]    col_next;
    logic [QRW-1:0]    row_next;
    logic [SIZE_W-1:0] col_cur;
    logic [SIZE_W-1:0] row_cur;
    logic [SIZE_W-1:0] col_adv;
    logic [SIZE_W-1:0] row_adv;
    logic              frame_end;

    always_comb
    begin
        col_cur = SIZE_W'(col_reg);
        row_cur = SIZE_W'(row_reg);
        if (col_cur >= qw)
        begin
            col_cur = '0;
            row_cur = row_cur + 11'd1;
        end
        if (row_cur >= qh)
        begin
            row_cur = '0;
        end

        frame_end = (col_cur + 11'd1 == qw) && (row_cur + 11'd1 == qh);

        col_adv = col_cur + 11'd1;
        row_adv = row_cur;
        if (col_adv >= qw)
        begin
            col_adv = '0;
            row_adv = row_cur + 11'd1;
            if (row_adv >= qh)
            begin
                row_adv = '0;
            end
        end
        col_next = col_adv[QCW-1:0];
        row_next = row_adv[QRW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accepted quad with its source pixel position.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] a_luma_reg [4];
    logic [SAMPLE_W-1:0] a_u_reg;
    logic [SAMPLE_W-1:0] a_v_reg;
    logic [SIZE_W-1:0]   a_x_reg;
    logic [SIZE_W-1:0]   a_y_reg;
    logic                a_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (load_b)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_luma_reg[0] <= luma_top_left;
            a_luma_reg[1] <= luma_top_right;
            a_luma_reg[2] <= luma_bottom_left;
            a_luma_reg[3] <= luma_bottom_right;
            a_u_reg       <= chroma_u;
            a_v_reg       <= chroma_v;
            a_x_reg       <= {col_cur[SIZE_W-2:0], 1'b0};
            a_y_reg       <= {row_cur[SIZE_W-2:0], 1'b0};
            a_last_reg    <= frame_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage A to B: chroma offsets and the quad's address frame. One
    // multiplier forms the address of the top-left pixel; the other three
    // follow from a column step and a row step.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]   u_ext;
    logic [SIZE_W-1:0]   v_ext;
    logic [SIZE_W-1:0]   cb_full;
    logic [SIZE_W-1:0]   g_full;
    logic [SIZE_W-1:0]   r_full;
    logic [SIZE_W-1:0]   mul_a;
    logic [SIZE_W-1:0]   mul_b;
    logic [2*SIZE_W-1:0] product;
    logic [2*SIZE_W-1:0] base_sum;
    logic [ADDR_W-1:0]   col_step;
    logic [ADDR_W-1:0]   row_step;

    always_comb
    begin
        u_ext = SIZE_W'(a_u_reg);
        v_ext = SIZE_W'(a_v_reg);
        // All three offsets stay within a signed 10-bit range.
        cb_full = (u_ext << 3) + (u_ext >> 3) - CB_BIAS;
        g_full  = G_BIAS - u_ext - (u_ext >> 1) - (u_ext >> 4)
                  - (v_ext << 1) - (v_ext >> 2) - (v_ext >> 4);
        r_full  = (v_ext << 2) + (v_ext >> 1) + (v_ext >> 4) - R_BIAS;

        if (rotate_reg)
        begin
            mul_a    = a_x_reg;
            mul_b    = h_eff;
            col_step = ADDR_W'(h_eff);
            row_step = 20'd1;
        end
        else
        begin
            mul_a    = h_eff - 11'd1 - a_y_reg;
            mul_b    = w_eff;
            col_step = 20'd1;
            row_step = 20'd0 - ADDR_W'(w_eff);
        end
        product  = mul_a * mul_b;
        base_sum = product + (2*SIZE_W)'(rotate_reg ? a_y_reg : a_x_reg);
    end

    // ------------------------------------------------------------------
    // Stage B: one quad, emitted one pixel per cycle while out_stall is low.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] b_luma_reg [4];
    logic [OFF_W-1:0]    b_cb_reg;
    logic [OFF_W-1:0]    b_g_reg;
    logic [OFF_W-1:0]    b_r_reg;
    logic [ADDR_W-1:0]   b_base_reg;
    logic [ADDR_W-1:0]   b_col_step_reg;
    logic [ADDR_W-1:0]   b_row_step_reg;
    logic                b_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            k_reg       <= '0;
        end
        else if (load_b)
        begin
            b_valid_reg <= 1'b1;
            k_reg       <= '0;
        end
        else if (b_finish)
        begin
            b_valid_reg <= 1'b0;
            k_reg       <= '0;
        end
        else if (out_take)
        begin
            k_reg <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_luma_reg     <= a_luma_reg;
            b_cb_reg       <= cb_full[OFF_W-1:0];
            b_g_reg        <= g_full[OFF_W-1:0];
            b_r_reg        <= r_full[OFF_W-1:0];
            b_base_reg     <= base_sum[ADDR_W-1:0];
            b_col_step_reg <= col_step;
            b_row_step_reg <= row_step;
            b_last_reg     <= a_last_reg;
        end
    end

    // Pixel of the current position: widened luma plus each offset, clamped.
    logic [SAMPLE_W-1:0]      luma_sel;
    logic signed [SIZE_W-1:0] luma8;
    logic signed [SIZE_W-1:0] b_sum;
    logic signed [SIZE_W-1:0] g_sum;
    logic signed [SIZE_W-1:0] r_sum;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    luma_sel = b_luma_reg[0];
            2'd1:    luma_sel = b_luma_reg[1];
            2'd2:    luma_sel = b_luma_reg[2];
            default: luma_sel = b_luma_reg[3];
        endcase
        luma8 = $signed({3'b000, luma_sel, 2'b00});
        b_sum = luma8 + SIZE_W'($signed(b_cb_reg));
        g_sum = luma8 + SIZE_W'($signed(b_g_reg));
        r_sum = luma8 + SIZE_W'($signed(b_r_reg));
    end

    assign out_valid     = b_valid_reg;
    assign pixel_word    = {clamp8(r_sum), clamp8(g_sum), clamp8(b_sum)};
    assign pixel_address = b_base_reg
                           + (k_reg[0] ? b_col_step_reg : 20'd0)
                           + (k_reg[1] ? b_row_step_reg : 20'd0);
    assign quad_last     = (k_reg == LAST_PIXEL);
    assign frame_last    = b_last_reg && (k_reg == LAST_PIXEL);

endmodule

// File: src/yrfr_checker.sv
// ----------------------------------------------------------------------------
// yrfr_port_checks
// Port-level checks of the converter: pixel grouping per quad, holding of a
// stalled result and the two-quad capacity of the block.
// ----------------------------------------------------------------------------
module yrfr_port_checks
    import yrfr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [PIXEL_W-1:0]   pixel_word,
    input logic [ADDR_W-1:0]    pixel_address,
    input logic                 quad_last,
    input logic                 frame_last
);

    logic       in_take;
    logic       out_take;
    logic       quad_done;
    pixel_sel_t pix_cnt_reg;
    logic [1:0] pend_reg;

    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign quad_done = out_take && quad_last;

    // Pixels taken within the current quad.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
        end
        else if (out_take)
        begin
            pix_cnt_reg <= pix_cnt_reg + 2'd1;
        end
    end

    // Quads accepted whose last pixel has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_take} - {1'b0, quad_done};
        end
    end

    // A stalled result holds its whole payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_word)
            && $stable(pixel_address) && $stable(quad_last) && $stable(frame_last))
        else $error("stalled result changed");

    // Every fourth taken pixel closes a quad, and only that one.
    a_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (quad_last == (pix_cnt_reg == LAST_PIXEL)))
        else $error("quad_last out of step with the pixel count");

    // The frame ends only on the closing pixel of a quad.
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> quad_last)
        else $error("frame_last without quad_last");

    // No quad is closed that was never accepted.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        quad_done |-> pend_reg != 2'd0)
        else $error("result quad without an accepted item");

    // With two quads held and none closing, the input must stall.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 && !quad_done |-> in_stall)
        else $error("input accepted beyond capacity");

endmodule

bind yuv420_to_rgb32_flip_rotate_top yrfr_port_checks u_yrfr_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_word    (pixel_word),
    .pixel_address (pixel_address),
    .quad_last     (quad_last),
    .frame_last    (frame_last)
);
